FILE: hw/rtl/upc_pkg.sv
// Package for the URI path check: character codes, window type and position limits.
// No dependencies; used by upc_match and uri_path_paranoid_check.
package upc_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_LOWE  = 8'h65;
  localparam logic [7:0] CH_UPE   = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWF  = 8'h66;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int WIN_DEPTH = 4;
  localparam int POS_W     = 3;
  localparam logic [POS_W-1:0] POS_MAX = 3'd7;

  // entry 0 holds the newest byte
  typedef logic [WIN_DEPTH-1:0][7:0] window_t;
  typedef logic [POS_W-1:0] pos_t;

endpackage

FILE: hw/rtl/upc_match.sv
// Pattern matcher: flags a suspicious sequence formed by the current byte,
// the window of the last four bytes and the position in the string. Uses upc_pkg.
module upc_match import upc_pkg::*; (
  input  logic [7:0] char_in,
  input  window_t    win,
  input  pos_t       pos,
  output logic       hit
);

  logic [7:0] b1, b2, b3, b4;
  logic       c_e, c_f, c_eos, b_enc;
  logic       hit_enc;

  always_comb begin
    b1 = win[0];
    b2 = win[1];
    b3 = win[2];
    b4 = win[3];
    c_e   = (char_in == CH_LOWE) || (char_in == CH_UPE);
    c_f   = (char_in == CH_LOWF) || (char_in == CH_UPF);
    c_eos = (char_in == CH_NUL) || (char_in == CH_SLASH);
    b_enc = (b1 == CH_TWO) && (b2 == CH_PCT);

    hit_enc = c_e && b_enc &&
              ((b3 == CH_SLASH) ||
               ((b3 == CH_DOT) && (b4 == CH_SLASH)) ||
               (pos == 3'd2) ||
               ((pos == 3'd3) && (b3 == CH_DOT)));

    hit = hit_enc ||
          ((char_in == CH_ZERO) && (b1 == CH_ZERO) && (b2 == CH_PCT)) ||
          (c_f && b_enc) ||
          ((char_in == CH_SLASH) && (b1 == CH_SLASH)) ||
          ((b2 == CH_SLASH) && (b1 == CH_DOT) && (c_eos || (char_in == CH_DOT))) ||
          ((pos == 3'd1) && (b1 == CH_DOT) && c_eos) ||
          ((pos == 3'd2) && (b2 == CH_DOT) && (b1 == CH_DOT) && c_eos);
  end

endmodule

FILE: hw/rtl/uri_path_paranoid_check.sv
// Top level of the streaming URI path check: window state, sticky reject flag
// and output register. Uses upc_pkg and upc_match.
//
// Usage:
//   Input channel in_*: one path byte per beat in in_tdata; a zero byte ends
//   the string. Output channel out_*: one verdict beat per terminator,
//   out_tdata[0] = 1 when the path passed every check, 0 when rejected.
//   Non-terminator bytes produce no output beat.
//   Throughput: one byte per cycle while no untaken verdict is held; each byte
//   is matched against the four-byte window and position combinationally
//   between the state registers and the output register.
//   Latency: the verdict appears on out_tvalid the cycle after the
//   terminator beat is accepted.
//   Stall: the output register holds its verdict until out_tready; while it
//   holds an untaken verdict, in_tready is low. Input bytes are accepted
//   whenever the output register is empty or being drained the same cycle.
//   Reset: synchronous, active low; clears the window, position count,
//   reject flag and output valid. in_tready is low while rst_n is low; the
//   first byte can be accepted as soon as rst_n goes high.
module uri_path_paranoid_check import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] path_ok, [7:1] zero
);

  window_t win_r, win_nxt;
  pos_t    pos_r, pos_nxt;
  logic    rej_r, rej_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    path_ok_r, path_ok_nxt;
  logic    in_fire, is_end, hit;

  upc_match u_match (
    .char_in (in_tdata),
    .win     (win_r),
    .pos     (pos_r),
    .hit     (hit)
  );

  assign in_tready  = rst_n && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign is_end     = (in_tdata == CH_NUL);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, path_ok_r};

  always_comb begin
    win_nxt       = win_r;
    pos_nxt       = pos_r;
    rej_nxt       = rej_r;
    path_ok_nxt   = path_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire) begin
      if (is_end) begin
        win_nxt       = '0;
        pos_nxt       = '0;
        rej_nxt       = 1'b0;
        path_ok_nxt   = !(rej_r || hit);
        out_valid_nxt = 1'b1;
      end else begin
        win_nxt = {win_r[WIN_DEPTH-2:0], in_tdata};
        rej_nxt = rej_r || hit;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + pos_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      pos_r       <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      pos_r       <= pos_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    path_ok_r <= path_ok_nxt;
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |=> (pos_r == '0) && !rej_r && (win_r == '0))
    else $error("state not cleared after terminator");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |=> out_valid_r)
    else $error("terminator did not produce a verdict");

  a_start_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> (win_r == '0) && !rej_r)
    else $error("window not empty at start of string");

  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while verdict is stalled");

  a_byte_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_end && !out_valid_r) |=> !out_valid_r)
    else $error("verdict produced without terminator");

endmodule
